>>> rtl/psr_pkg.sv
// ---------------------------------------------------------------------------
// Polyphase sinc resampler package
// Shared sizes, types and state encoding for the resampler blocks.
// ---------------------------------------------------------------------------
package psr_pkg;

  localparam int TAPS       = 32;
  localparam int PHASES     = 64;
  localparam int RING_DEPTH = 64;

  localparam int COEF_SLOTS = PHASES * TAPS;
  localparam int COEF_IDX_W = $clog2(COEF_SLOTS);
  localparam int TAP_W      = $clog2(TAPS);
  localparam int PH_W       = (PHASES > 1) ? $clog2(PHASES) : 1;
  localparam int RING_AW    = $clog2(RING_DEPTH);

  localparam int STEP_W     = 21;
  localparam logic [STEP_W-1:0] STEP_RESET = 21'd196608;

  localparam int SAMPLE_W   = 16;
  localparam int ADDR_W     = 11;
  localparam int COEF_W     = 18;
  localparam int PROD_W     = SAMPLE_W + COEF_W;
  localparam int ACC_W      = PROD_W + TAP_W + 1;
  localparam int CNT_W      = 48;
  localparam int TIME_W     = 64;
  localparam int IDX_W      = 50;

  typedef enum logic {
    KIND_PUSH,
    KIND_COEF
  } item_kind_e;

  typedef struct packed {
    item_kind_e                  kind;
    logic signed [SAMPLE_W-1:0]  sample;
    logic        [ADDR_W-1:0]    addr;
    logic signed [COEF_W-1:0]    value;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SETUP,
    ST_MAC,
    ST_SCALE,
    ST_ROUND,
    ST_EMIT
  } state_e;

endpackage

>>> rtl/polyphase_sinc_resampler.sv
// Each output is formed by the single multiply-accumulate loop, and a sample transaction
// yields at most two outputs. The engine takes the next queued item only when idle.
// Reset clears all control state and loads STEP_RESET into the step register;
// sample and coefficient memories are undefined until written and need no clearing pass.
// ---------------------------------------------------------------------------
// Polyphase sinc resampler
// Sample-rate converter built from a queueing front end and a
// multiply-accumulate engine that forms each output sample.
// ---------------------------------------------------------------------------
module polyphase_sinc_resampler (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic        [psr_pkg::STEP_W-1:0]    cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 opcode_i,
  input  logic signed [psr_pkg::SAMPLE_W-1:0]  sample_in_i,
  input  logic        [psr_pkg::ADDR_W-1:0]    coef_address_i,
  input  logic signed [psr_pkg::COEF_W-1:0]    coef_value_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [psr_pkg::SAMPLE_W-1:0]  out_sample_o,
  output logic                                 last_o
);

  logic [psr_pkg::STEP_W-1:0] step_q;
  psr_pkg::queue_head_t       head;
  logic                       pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= psr_pkg::STEP_RESET;
    end else if (cfg_we_i) begin
      step_q <= cfg_wdata_i;
    end
  end

  psr_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .opcode_i       (opcode_i),
    .sample_in_i    (sample_in_i),
    .coef_address_i (coef_address_i),
    .coef_value_i   (coef_value_i),
    .step_i         (step_q),
    .head_o         (head),
    .pop_i          (pop)
  );

  psr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .pop_o        (pop),
    .step_i       (step_q),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_sample_o (out_sample_o),
    .last_o       (last_o)
  );

endmodule

>>> rtl/psr_front.sv
// ---------------------------------------------------------------------------
// Resampler front end
// Accepts input transactions, drops those with no effect, and queues the
// rest in a two-entry queue for the processing engine.
// ---------------------------------------------------------------------------
module psr_front (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 opcode_i,
  input  logic signed [psr_pkg::SAMPLE_W-1:0]  sample_in_i,
  input  logic        [psr_pkg::ADDR_W-1:0]    coef_address_i,
  input  logic signed [psr_pkg::COEF_W-1:0]    coef_value_i,
  input  logic        [psr_pkg::STEP_W-1:0]    step_i,
  output psr_pkg::queue_head_t                 head_o,
  input  logic                                 pop_i
);

  psr_pkg::item_t slot_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     count_q, count_d;
  logic           accept, keep, push;
  psr_pkg::item_t item_in;

  assign in_ready_o = (count_q != 2'd2);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    item_in.kind   = opcode_i ? psr_pkg::KIND_COEF : psr_pkg::KIND_PUSH;
    item_in.sample = sample_in_i;
    item_in.addr   = coef_address_i;
    item_in.value  = coef_value_i;
    if (opcode_i) begin
      keep = (32'(coef_address_i) < 32'(psr_pkg::COEF_SLOTS));
    end else begin
      keep = (step_i != '0);
    end
  end

  assign push = accept && keep;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= item_in;
    end
  end

  assign head_o.valid = (count_q != 2'd0);
  assign head_o.item  = slot_q[rd_ptr_q];

endmodule

>>> rtl/psr_back.sv
// ---------------------------------------------------------------------------
// Resampler processing engine
// Stores samples and coefficients, runs the polyphase dot product one tap
// per cycle, scales the sum and presents results through an output register.
// ---------------------------------------------------------------------------
module psr_back (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  psr_pkg::queue_head_t                 head_i,
  output logic                                 pop_o,
  input  logic        [psr_pkg::STEP_W-1:0]    step_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [psr_pkg::SAMPLE_W-1:0]  out_sample_o,
  output logic                                 last_o
);

  localparam int RING_AW = psr_pkg::RING_AW;
  localparam int CI_W    = psr_pkg::COEF_IDX_W;
  localparam logic signed [psr_pkg::ACC_W-1:0] ONE_POS = psr_pkg::ACC_W'(64'sd1 <<< 31);
  localparam logic signed [psr_pkg::ACC_W-1:0] ONE_NEG = -ONE_POS;

  logic signed [psr_pkg::SAMPLE_W-1:0] ring_mem [psr_pkg::RING_DEPTH];
  logic signed [psr_pkg::COEF_W-1:0]   coef_mem [psr_pkg::COEF_SLOTS];

  psr_pkg::state_e state_q, state_d;

  logic signed [psr_pkg::CNT_W-1:0]  cnt_q;
  logic signed [psr_pkg::TIME_W-1:0] time_q;
  logic        [RING_AW-1:0]         wptr_q;
  logic        [1:0]                 n_q;
  logic        [psr_pkg::TAP_W:0]    tap_q;
  logic        [psr_pkg::PH_W-1:0]   phase_q;
  logic signed [psr_pkg::IDX_W-1:0]  idx_q;
  logic signed [psr_pkg::IDX_W-1:0]  dist_q;
  logic signed [psr_pkg::COEF_W-1:0]   coef_rd_q;
  logic signed [psr_pkg::SAMPLE_W-1:0] ring_rd_q;
  logic                              ok_q, v1_q, v2_q;
  logic signed [psr_pkg::PROD_W-1:0] prod_q;
  logic signed [psr_pkg::ACC_W-1:0]  acc_q;
  logic signed [32:0]                clamp_q;
  logic signed [psr_pkg::SAMPLE_W-1:0] val_q;
  logic                              out_valid_q;
  logic signed [psr_pkg::SAMPLE_W-1:0] out_sample_q;
  logic                              out_last_q;

  logic                              due, more, issue, mac_done, emit_load;
  logic                              take_push, take_coef;
  logic signed [psr_pkg::TIME_W-1:0] lhs, rhs;
  logic signed [psr_pkg::IDX_W-1:0]  first;
  logic        [31:0]                ph_full;
  logic        [RING_AW-1:0]         wptr_next, dd, raddr;
  logic        [CI_W-1:0]            caddr;
  logic                              ok_now;
  logic        [47:0]                pos_prod;
  logic        [32:0]                neg_mag;
  logic        [16:0]                neg_q;
  logic signed [psr_pkg::SAMPLE_W-1:0] val_d;
  logic signed [32:0]                clamp_d;

  assign lhs = time_q + psr_pkg::TIME_W'((psr_pkg::TAPS / 2) * 65536);
  assign rhs = {cnt_q, 16'b0};
  assign due = (lhs <= rhs);
  assign more = (n_q < 2'd2) && due;

  assign first   = psr_pkg::IDX_W'(time_q >>> 16) - psr_pkg::IDX_W'(psr_pkg::TAPS / 2 - 1);
  assign ph_full = (32'(time_q[15:0]) * 32'(psr_pkg::PHASES)) >> 16;

  assign wptr_next = (wptr_q == RING_AW'(psr_pkg::RING_DEPTH - 1)) ? '0 : wptr_q + 1'b1;

  assign issue    = (state_q == psr_pkg::ST_MAC) &&
                    (tap_q < (psr_pkg::TAP_W + 1)'(psr_pkg::TAPS));
  assign mac_done = (state_q == psr_pkg::ST_MAC) && !issue && !v1_q && !v2_q;
  assign ok_now   = (idx_q >= 0) && (dist_q >= 0) &&
                    (dist_q < psr_pkg::IDX_W'(psr_pkg::RING_DEPTH));
  assign dd       = dist_q[RING_AW-1:0];
  assign raddr    = (wptr_q >= dd) ? wptr_q - dd
                  : RING_AW'((RING_AW + 1)'(wptr_q) + (RING_AW + 1)'(psr_pkg::RING_DEPTH)
                             - (RING_AW + 1)'(dd));
  assign caddr    = CI_W'(CI_W'(phase_q) * CI_W'(psr_pkg::TAPS)) + CI_W'(tap_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      psr_pkg::ST_IDLE: begin
        if (head_i.valid && head_i.item.kind == psr_pkg::KIND_PUSH) begin
          state_d = psr_pkg::ST_CHECK;
        end
      end
      psr_pkg::ST_CHECK: state_d = more ? psr_pkg::ST_SETUP : psr_pkg::ST_IDLE;
      psr_pkg::ST_SETUP: state_d = psr_pkg::ST_MAC;
      psr_pkg::ST_MAC:   state_d = mac_done ? psr_pkg::ST_SCALE : psr_pkg::ST_MAC;
      psr_pkg::ST_SCALE: state_d = psr_pkg::ST_ROUND;
      psr_pkg::ST_ROUND: state_d = psr_pkg::ST_EMIT;
      psr_pkg::ST_EMIT: begin
        if (emit_load) begin
          state_d = more ? psr_pkg::ST_CHECK : psr_pkg::ST_IDLE;
        end
      end
      default:  state_d = psr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    pop_o     = 1'b0;
    take_push = 1'b0;
    take_coef = 1'b0;
    emit_load = 1'b0;
    case (state_q)
      psr_pkg::ST_IDLE: begin
        pop_o     = head_i.valid;
        take_push = head_i.valid && head_i.item.kind == psr_pkg::KIND_PUSH;
        take_coef = head_i.valid && head_i.item.kind == psr_pkg::KIND_COEF;
      end
      psr_pkg::ST_EMIT:  emit_load = !out_valid_q || out_ready_i;
      default: begin
        pop_o = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (acc_q > ONE_POS) begin
      clamp_d = 33'(ONE_POS);
    end else if (acc_q < ONE_NEG) begin
      clamp_d = 33'(ONE_NEG);
    end else begin
      clamp_d = 33'(acc_q);
    end
    pos_prod = (48'(clamp_q) << 15) - 48'(clamp_q) + 48'h0000_4000_0000;
    neg_mag  = 33'(-clamp_q) + 33'd32768;
    neg_q    = neg_mag[32:16];
    if (clamp_q >= 0) begin
      val_d = pos_prod[46:31];
    end else begin
      val_d = 16'(-neg_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_push) begin
      ring_mem[wptr_next] <= head_i.item.sample;
    end
    ring_rd_q <= ring_mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (take_coef) begin
      coef_mem[CI_W'(head_i.item.addr)] <= head_i.item.value;
    end
    coef_rd_q <= coef_mem[caddr];
  end

  always_ff @(posedge clk_i) begin
    ok_q   <= ok_now;
    prod_q <= ok_q ? psr_pkg::PROD_W'(coef_rd_q * ring_rd_q) : '0;
    if (state_q == psr_pkg::ST_CHECK) begin
      idx_q   <= first;
      phase_q <= psr_pkg::PH_W'(ph_full);
    end
    if (state_q == psr_pkg::ST_SETUP) begin
      dist_q <= psr_pkg::IDX_W'(cnt_q) - idx_q;
      acc_q  <= '0;
    end
    if (issue) begin
      idx_q  <= idx_q + 1'b1;
      dist_q <= dist_q - 1'b1;
    end
    if (state_q == psr_pkg::ST_MAC && v2_q) begin
      acc_q <= acc_q + psr_pkg::ACC_W'(prod_q);
    end
    if (state_q == psr_pkg::ST_SCALE) begin
      clamp_q <= clamp_d;
    end
    if (state_q == psr_pkg::ST_ROUND) begin
      val_q <= val_d;
    end
    if (emit_load) begin
      out_sample_q <= val_q;
      out_last_q   <= !more;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= psr_pkg::ST_IDLE;
      cnt_q       <= '1;
      time_q      <= psr_pkg::TIME_W'((psr_pkg::TAPS / 2 - 1) * 65536);
      wptr_q      <= RING_AW'(psr_pkg::RING_DEPTH - 1);
      n_q         <= 2'd0;
      tap_q       <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      v1_q    <= issue;
      v2_q    <= v1_q;
      if (take_push) begin
        cnt_q  <= cnt_q + 1'b1;
        wptr_q <= wptr_next;
        n_q    <= 2'd0;
      end
      if (state_q == psr_pkg::ST_SETUP) begin
        tap_q <= '0;
      end else if (issue) begin
        tap_q <= tap_q + 1'b1;
      end
      if (state_q == psr_pkg::ST_ROUND) begin
        time_q <= time_q + psr_pkg::TIME_W'(step_i);
        n_q    <= n_q + 2'd1;
      end
      if (emit_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_sample_o = out_sample_q;
  assign last_o       = out_last_q;

endmodule

>>> bench/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Polyphase sinc resampler testbench
// Loads the coefficient table, pushes directed and random samples under
// several step settings, and checks every output transaction against a
// behavioural predictor of the converter, with random idling on both sides.
// ---------------------------------------------------------------------------
module tb;

  localparam int STALL_LIMIT = 20000;
  localparam int SETTLE      = 160;

  typedef struct {
    logic signed [psr_pkg::SAMPLE_W-1:0] sample;
    logic                                last;
  } out_t;

  logic                                clk_i = 1'b0;
  logic                                rst_ni = 1'b0;
  logic                                cfg_we_i = 1'b0;
  logic        [psr_pkg::STEP_W-1:0]   cfg_wdata_i = '0;
  logic                                in_valid_i = 1'b0;
  logic                                in_ready_o;
  logic                                opcode_i = 1'b0;
  logic signed [psr_pkg::SAMPLE_W-1:0] sample_in_i = '0;
  logic        [psr_pkg::ADDR_W-1:0]   coef_address_i = '0;
  logic signed [psr_pkg::COEF_W-1:0]   coef_value_i = '0;
  logic                                out_valid_o;
  logic                                out_ready_i = 1'b0;
  logic signed [psr_pkg::SAMPLE_W-1:0] out_sample_o;
  logic                                last_o;

  logic signed [psr_pkg::SAMPLE_W-1:0] ring_mem [psr_pkg::RING_DEPTH];
  logic signed [psr_pkg::COEF_W-1:0]   coef_mem [psr_pkg::COEF_SLOTS];
  longint                              sample_count;
  longint                              out_time;
  logic        [psr_pkg::STEP_W-1:0]   step_reg;
  out_t                                pending_outputs [$];
  int                                  error_count = 0;
  int                                  idle_cycles = 0;
  bit                                  gaps_on = 1'b1;

  polyphase_sinc_resampler u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .opcode_i       (opcode_i),
    .sample_in_i    (sample_in_i),
    .coef_address_i (coef_address_i),
    .coef_value_i   (coef_value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_sample_o   (out_sample_o),
    .last_o         (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic longint ring_tap(longint idx);
    if (idx < 0 || idx > sample_count || sample_count - idx >= psr_pkg::RING_DEPTH) return 0;
    return longint'(ring_mem[idx % psr_pkg::RING_DEPTH]);
  endfunction

  function automatic logic signed [psr_pkg::SAMPLE_W-1:0] filter_output();
    longint first;
    longint phase;
    longint acc;
    first = (out_time >>> 16) - psr_pkg::TAPS / 2 + 1;
    phase = ((out_time & 64'hFFFF) * psr_pkg::PHASES) >>> 16;
    acc = 0;
    for (int t = 0; t < psr_pkg::TAPS; t++)
      acc += longint'(coef_mem[phase * psr_pkg::TAPS + t]) * ring_tap(first + t);
    if (acc > (64'sd1 <<< 31)) acc = 64'sd1 <<< 31;
    else if (acc < -(64'sd1 <<< 31)) acc = -(64'sd1 <<< 31);
    if (acc >= 0) acc = (acc * 32767 + (64'sd1 <<< 30)) >>> 31;
    else acc = -((-acc + (64'sd1 <<< 15)) >>> 16);
    return acc[psr_pkg::SAMPLE_W-1:0];
  endfunction

  task automatic predict_item(psr_pkg::item_kind_e kind,
                              logic signed [psr_pkg::SAMPLE_W-1:0] smp,
                              logic [psr_pkg::ADDR_W-1:0] addr,
                              logic signed [psr_pkg::COEF_W-1:0] val);
    out_t res [2];
    int   n;
    n = 0;
    if (kind == psr_pkg::KIND_COEF) begin
      if (addr < psr_pkg::COEF_SLOTS) coef_mem[addr] = val;
      return;
    end
    if (step_reg == 0) return;
    sample_count++;
    ring_mem[sample_count % psr_pkg::RING_DEPTH] = smp;
    while (n < 2 &&
           out_time + longint'(psr_pkg::TAPS / 2) * 65536 <= sample_count * 65536) begin
      res[n].sample = filter_output();
      res[n].last = 1'b0;
      out_time += longint'(step_reg);
      n++;
    end
    if (n > 0) res[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) pending_outputs.push_back(res[i]);
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    error_count++;
  endtask

  always @(posedge clk_i) begin
    out_t want;
    if (out_valid_o && out_ready_i) begin
      if (pending_outputs.size() == 0) begin
        $display("%0t: output transaction with nothing expected", $time);
        error_count++;
      end else begin
        want = pending_outputs.pop_front();
        if (out_sample_o !== want.sample) report_mismatch("out_sample", out_sample_o, want.sample);
        if (last_o !== want.last) report_mismatch("last", last_o, want.last);
      end
    end
  end

  always @(negedge clk_i)
    out_ready_i <= gaps_on ? ($urandom_range(99) >= 6) : 1'b1;

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("** polyphase_sinc_resampler: FAILED **");
      $finish;
    end
  end

  task automatic send_item(psr_pkg::item_kind_e kind,
                           logic signed [psr_pkg::SAMPLE_W-1:0] smp,
                           logic [psr_pkg::ADDR_W-1:0] addr,
                           logic signed [psr_pkg::COEF_W-1:0] val);
    if (gaps_on && $urandom_range(99) < 6) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat ($urandom_range(3)) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i     <= 1'b1;
    opcode_i       <= kind;
    sample_in_i    <= smp;
    coef_address_i <= addr;
    coef_value_i   <= val;
    do @(posedge clk_i); while (!in_ready_o);
    predict_item(kind, smp, addr, val);
  endtask

  task automatic send_push(logic signed [psr_pkg::SAMPLE_W-1:0] smp);
    send_item(psr_pkg::KIND_PUSH, smp, psr_pkg::ADDR_W'($urandom),
              psr_pkg::COEF_W'($urandom));
  endtask

  task automatic send_coef(logic [psr_pkg::ADDR_W-1:0] addr,
                           logic signed [psr_pkg::COEF_W-1:0] val);
    send_item(psr_pkg::KIND_COEF, psr_pkg::SAMPLE_W'($urandom), addr, val);
  endtask

  task automatic drain_outputs();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (pending_outputs.size() == 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_step(logic [psr_pkg::STEP_W-1:0] value);
    drain_outputs();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    step_reg = value;
  endtask

  function automatic logic signed [psr_pkg::COEF_W-1:0] random_coef();
    if ($urandom_range(3) == 0) return psr_pkg::COEF_W'($urandom);
    return psr_pkg::COEF_W'($signed($urandom_range(8191)) - 4096);
  endfunction

  function automatic logic signed [psr_pkg::SAMPLE_W-1:0] random_sample();
    case ($urandom_range(9))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      default: return psr_pkg::SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic test_coef_load();
    for (int a = 0; a < psr_pkg::COEF_SLOTS; a++) begin
      case (a % 97)
        0:       send_coef(psr_pkg::ADDR_W'(a), 18'sh20000);
        1:       send_coef(psr_pkg::ADDR_W'(a), 18'sh1FFFF);
        default: send_coef(psr_pkg::ADDR_W'(a), random_coef());
      endcase
    end
  endtask

  task automatic test_directed_samples();
    logic signed [psr_pkg::SAMPLE_W-1:0] edges [6] =
      '{16'sh7FFF, 16'sh8000, 0, -1, 1, 16'sh5555};
    for (int i = 0; i < 20; i++) send_push(edges[i % 6]);
    send_coef(psr_pkg::ADDR_W'(psr_pkg::COEF_SLOTS - 1), 18'sh20000);
    send_coef(psr_pkg::ADDR_W'(0), 18'sh1FFFF);
    send_push(16'sh7FFF);
  endtask

  task automatic test_zero_step();
    write_step('0);
    repeat (4) send_push(random_sample());
    write_step(psr_pkg::STEP_RESET);
    send_push(random_sample());
  endtask

  task automatic test_random_phase(logic [psr_pkg::STEP_W-1:0] step, int count);
    write_step(step);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 5) send_coef(psr_pkg::ADDR_W'($urandom), random_coef());
      else send_push(random_sample());
    end
  endtask

  task automatic test_random();
    logic [psr_pkg::STEP_W-1:0] steps [7] = '{21'd1, 21'h1FFFFF, 21'd32768, 21'd1572864,
                                              psr_pkg::STEP_RESET, 21'd70000, 21'd500000};
    for (int p = 0; p < 7; p++) test_random_phase(steps[p], 160);
    for (int p = 0; p < 4; p++)
      test_random_phase(psr_pkg::STEP_W'($urandom_range(1572864, 32768)), 120);
    gaps_on = 1'b0;
    test_random_phase(psr_pkg::STEP_W'($urandom_range(200000, 32768)), 150);
    gaps_on = 1'b1;
  endtask

  initial begin
    ring_mem     = '{default: '0};
    coef_mem     = '{default: '0};
    sample_count = -1;
    out_time     = longint'(psr_pkg::TAPS / 2 - 1) * 65536;
    step_reg     = psr_pkg::STEP_RESET;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_coef_load();
    test_directed_samples();
    test_zero_step();
    test_random();
    drain_outputs();
    if (error_count == 0) $display("** polyphase_sinc_resampler: PASSED **");
    else $display("** polyphase_sinc_resampler: FAILED **");
    $finish;
  end

endmodule

>>> sim.f
rtl/psr_pkg.sv
rtl/psr_front.sv
rtl/psr_back.sv
rtl/polyphase_sinc_resampler.sv
bench/tb.sv
